[src/pfke_pkg.sv]
// Package of the flow key extractor: types, codes and constants shared by its files.
`default_nettype none
package pfke_pkg;

    // Default width of the frame byte counter.
    localparam int OFFSET_BITS_DEF = 8;

    // Depth of the key queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 2;

    // Ethertypes and IP protocol numbers the parser knows.
    localparam logic [15:0] ETH_LLC_LIMIT = 16'h0600;
    localparam logic [15:0] ETH_NON_SNAP  = 16'h05FF;
    localparam logic [15:0] ETH_VLAN      = 16'h8100;
    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_ARP       = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] VLAN_NONE     = 16'hFFFF;
    localparam logic [15:0] FRAG_MASK     = 16'h3FFF;

    // Header currently being parsed.
    typedef enum logic [3:0] {
        ST_ETH,
        ST_LLC,
        ST_VLAN,
        ST_IPV4,
        ST_TCP,
        ST_UDP,
        ST_ICMP,
        ST_ARP,
        ST_DONE
    } t_stage;

    // Raw captures and validity flags of one frame, handed from parser to output stage.
    typedef struct packed {
        logic [15:0] port;
        logic [47:0] mac_dst;
        logic [47:0] mac_src;
        logic [15:0] ether_type;
        logic [15:0] tci;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [15:0] l4_src;
        logic [15:0] l4_dst;
        logic        l2_ok;
        logic        vlan_ok;
        logic        ip_ok;
        logic        l4_pend;
        logic        l4_ok;
        logic        arp_done;
        logic        arp_addr;
    } t_raw;

endpackage
`default_nettype wire

[src/pfke_if.sv]
// Channel interfaces of the flow key extractor: frame bytes in, flow keys out.
`default_nettype none
interface pfke_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pkt_byte;
    logic        end_of_packet;
    logic [15:0] ingress_port;

    modport source (output valid, pkt_byte, end_of_packet, ingress_port, input ready);
    modport sink (input valid, pkt_byte, end_of_packet, ingress_port, output ready);
endinterface

interface pfke_key_if;
    logic        valid;
    logic        ready;
    logic [15:0] key_port;
    logic [15:0] key_vlan;
    logic [2:0]  key_pcp;
    logic [47:0] key_mac_src;
    logic [47:0] key_mac_dst;
    logic [15:0] key_ether_type;
    logic [31:0] key_ip_src;
    logic [31:0] key_ip_dst;
    logic [7:0]  key_ip_proto;
    logic [7:0]  key_tos;
    logic [15:0] key_l4_src;
    logic [15:0] key_l4_dst;

    modport source (output valid, key_port, key_vlan, key_pcp, key_mac_src, key_mac_dst,
                    key_ether_type, key_ip_src, key_ip_dst, key_ip_proto, key_tos,
                    key_l4_src, key_l4_dst, input ready);
    modport sink (input valid, key_port, key_vlan, key_pcp, key_mac_src, key_mac_dst,
                  key_ether_type, key_ip_src, key_ip_dst, key_ip_proto, key_tos,
                  key_l4_src, key_l4_dst, output ready);
endinterface
`default_nettype wire

[src/pfke_parse.sv]
// Streaming header parser: captures header fields byte by byte and pushes them at frame end.
`default_nettype none
module pfke_parse #(
    parameter int OFFSET_BITS = pfke_pkg::OFFSET_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pfke_in_if.sink       i_in,
    input  wire logic     i_q_ready,
    output pfke_pkg::t_raw o_raw,
    output logic          o_push
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    // Control state.
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    pfke_pkg::t_stage       r_stage, n_stage;
    logic [7:0]             r_need, n_need;
    logic                   r_hdr_ok, n_hdr_ok;
    logic                   r_snap_ok, n_snap_ok;
    logic                   r_plen4, n_plen4;
    logic                   r_l2_ok, n_l2_ok;
    logic                   r_vlan_ok, n_vlan_ok;
    logic                   r_ip_ok, n_ip_ok;
    logic                   r_l4_pend, n_l4_pend;
    logic                   r_l4_ok, n_l4_ok;
    logic                   r_arp_done, n_arp_done;
    logic                   r_arp_addr, n_arp_addr;

    // Capture registers.
    logic [15:0] r_port, n_port;
    logic [47:0] r_mac_dst, n_mac_dst;
    logic [47:0] r_mac_src, n_mac_src;
    logic [15:0] r_type, n_type;
    logic [15:0] r_tci, n_tci;
    logic [15:0] r_tmp, n_tmp;
    logic [31:0] r_ip_src, n_ip_src;
    logic [31:0] r_ip_dst, n_ip_dst;
    logic [7:0]  r_proto, n_proto;
    logic [7:0]  r_tos, n_tos;
    logic [15:0] r_l4_src, n_l4_src;
    logic [15:0] r_l4_dst, n_l4_dst;

    logic                   acc;
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] rel_full;
    logic [7:0]             rel;
    logic [15:0]            word;

    // Header that follows a resolved ethertype.
    function automatic pfke_pkg::t_stage f_dispatch(input logic [15:0] t, input logic vlan_seen);
        pfke_pkg::t_stage s;
        s = pfke_pkg::ST_DONE;
        if (t == pfke_pkg::ETH_VLAN && !vlan_seen) begin
            s = pfke_pkg::ST_VLAN;
        end else if (t == pfke_pkg::ETH_IPV4) begin
            s = pfke_pkg::ST_IPV4;
        end else if (t == pfke_pkg::ETH_ARP) begin
            s = pfke_pkg::ST_ARP;
        end
        return s;
    endfunction

    assign acc       = i_in.valid && i_in.ready;
    assign i_in.ready = i_q_ready;
    assign b         = i_in.pkt_byte;
    assign rel_full  = r_off - r_start;
    assign rel       = rel_full[7:0];

    // Per-byte update of the parser state.
    always_comb begin
        n_off = r_off; n_start = r_start; n_stage = r_stage; n_need = r_need;
        n_hdr_ok = r_hdr_ok; n_snap_ok = r_snap_ok; n_plen4 = r_plen4;
        n_l2_ok = r_l2_ok; n_vlan_ok = r_vlan_ok; n_ip_ok = r_ip_ok;
        n_l4_pend = r_l4_pend; n_l4_ok = r_l4_ok;
        n_arp_done = r_arp_done; n_arp_addr = r_arp_addr;
        n_port = r_port; n_mac_dst = r_mac_dst; n_mac_src = r_mac_src;
        n_type = r_type; n_tci = r_tci; n_tmp = r_tmp;
        n_ip_src = r_ip_src; n_ip_dst = r_ip_dst; n_proto = r_proto; n_tos = r_tos;
        n_l4_src = r_l4_src; n_l4_dst = r_l4_dst;
        word = {r_type[7:0], b};
        if (acc) begin
            if (r_off != OFF_MAX) begin
                n_off = r_off + 1'b1;
            end
            if (r_off == '0) begin
                n_port = i_in.ingress_port;
            end
            case (r_stage)
                pfke_pkg::ST_ETH: begin
                    if (rel < 8'd6) begin
                        n_mac_dst = {r_mac_dst[39:0], b};
                    end else if (rel < 8'd12) begin
                        n_mac_src = {r_mac_src[39:0], b};
                    end else begin
                        n_type = word;
                    end
                    if (rel == 8'd13) begin
                        n_start = r_off + 1'b1;
                        if (word < pfke_pkg::ETH_LLC_LIMIT) begin
                            n_stage = pfke_pkg::ST_LLC;
                        end else begin
                            n_l2_ok = 1'b1;
                            n_stage = f_dispatch(word, 1'b0);
                        end
                    end
                end
                pfke_pkg::ST_LLC: begin
                    case (rel)
                        8'd0: n_snap_ok = (b == 8'hAA);
                        8'd1: n_snap_ok = r_snap_ok && (b == 8'hAA);
                        8'd2: n_snap_ok = r_snap_ok && (b == 8'h03);
                        8'd3, 8'd4, 8'd5: n_snap_ok = r_snap_ok && (b == 8'h00);
                        8'd6: n_type = word;
                        8'd7: begin
                            n_l2_ok = 1'b1;
                            n_start = r_off + 1'b1;
                            if (r_snap_ok) begin
                                n_type  = word;
                                n_stage = f_dispatch(word, 1'b0);
                            end else begin
                                n_type  = pfke_pkg::ETH_NON_SNAP;
                                n_stage = pfke_pkg::ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                pfke_pkg::ST_VLAN: begin
                    case (rel)
                        8'd0, 8'd1: n_tci = {r_tci[7:0], b};
                        8'd2: n_tmp = {r_tmp[7:0], b};
                        8'd3: begin
                            n_vlan_ok = 1'b1;
                            n_type    = {r_tmp[7:0], b};
                            n_start   = r_off + 1'b1;
                            n_stage   = f_dispatch({r_tmp[7:0], b}, 1'b1);
                        end
                        default: ;
                    endcase
                end
                pfke_pkg::ST_IPV4: begin
                    case (rel)
                        8'd0: begin
                            n_need   = {2'b00, b[3:0], 2'b00};
                            n_hdr_ok = (b[3:0] >= 4'd5);
                        end
                        8'd1: n_tos = b;
                        8'd6, 8'd7: n_tmp = {r_tmp[7:0], b};
                        8'd9: n_proto = b;
                        8'd12, 8'd13, 8'd14, 8'd15: n_ip_src = {r_ip_src[23:0], b};
                        8'd16, 8'd17, 8'd18, 8'd19: n_ip_dst = {r_ip_dst[23:0], b};
                        default: ;
                    endcase
                    // Header complete once the IHL length has arrived.
                    if (rel == 8'd19 && !r_hdr_ok) begin
                        n_stage = pfke_pkg::ST_DONE;
                    end else if (rel >= 8'd19 && rel == r_need - 8'd1) begin
                        n_ip_ok = 1'b1;
                        n_start = r_off + 1'b1;
                        if ((r_tmp & pfke_pkg::FRAG_MASK) != 16'h0000) begin
                            n_stage = pfke_pkg::ST_DONE;
                        end else if (r_proto == pfke_pkg::PROTO_TCP) begin
                            n_stage = pfke_pkg::ST_TCP;  n_l4_pend = 1'b1;
                        end else if (r_proto == pfke_pkg::PROTO_UDP) begin
                            n_stage = pfke_pkg::ST_UDP;  n_l4_pend = 1'b1;
                        end else if (r_proto == pfke_pkg::PROTO_ICMP) begin
                            n_stage = pfke_pkg::ST_ICMP; n_l4_pend = 1'b1;
                        end else begin
                            n_stage = pfke_pkg::ST_DONE;
                        end
                    end
                end
                pfke_pkg::ST_TCP: begin
                    case (rel)
                        8'd0, 8'd1: n_l4_src = {r_l4_src[7:0], b};
                        8'd2, 8'd3: n_l4_dst = {r_l4_dst[7:0], b};
                        8'd12: begin
                            n_need   = {2'b00, b[7:4], 2'b00};
                            n_hdr_ok = (b[7:4] >= 4'd5);
                        end
                        default: ;
                    endcase
                    if (rel == 8'd19 && !r_hdr_ok) begin
                        n_stage = pfke_pkg::ST_DONE;
                    end else if (rel >= 8'd19 && rel == r_need - 8'd1) begin
                        n_l4_ok = 1'b1;
                        n_stage = pfke_pkg::ST_DONE;
                    end
                end
                pfke_pkg::ST_UDP: begin
                    case (rel)
                        8'd0, 8'd1: n_l4_src = {r_l4_src[7:0], b};
                        8'd2, 8'd3: n_l4_dst = {r_l4_dst[7:0], b};
                        8'd7: begin
                            n_l4_ok = 1'b1;
                            n_stage = pfke_pkg::ST_DONE;
                        end
                        default: ;
                    endcase
                end
                pfke_pkg::ST_ICMP: begin
                    case (rel)
                        8'd0: n_l4_src = {8'h00, b};
                        8'd1: n_l4_dst = {8'h00, b};
                        8'd3: begin
                            n_l4_ok = 1'b1;
                            n_stage = pfke_pkg::ST_DONE;
                        end
                        default: ;
                    endcase
                end
                pfke_pkg::ST_ARP: begin
                    case (rel)
                        8'd2, 8'd3: n_tmp = {r_tmp[7:0], b};
                        8'd5: n_plen4 = (b == 8'd4);
                        8'd7: n_proto = b;
                        8'd14, 8'd15, 8'd16, 8'd17: n_ip_src = {r_ip_src[23:0], b};
                        8'd24, 8'd25, 8'd26: n_ip_dst = {r_ip_dst[23:0], b};
                        8'd27: begin
                            n_ip_dst   = {r_ip_dst[23:0], b};
                            n_arp_done = 1'b1;
                            n_arp_addr = (r_tmp == pfke_pkg::ETH_IPV4) && r_plen4;
                            n_stage    = pfke_pkg::ST_DONE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // The last byte's updates are already folded into what is pushed.
    assign o_push = acc && i_in.end_of_packet;
    always_comb begin
        o_raw.port       = n_port;
        o_raw.mac_dst    = n_mac_dst;
        o_raw.mac_src    = n_mac_src;
        o_raw.ether_type = n_type;
        o_raw.tci        = n_tci;
        o_raw.ip_src     = n_ip_src;
        o_raw.ip_dst     = n_ip_dst;
        o_raw.proto      = n_proto;
        o_raw.tos        = n_tos;
        o_raw.l4_src     = n_l4_src;
        o_raw.l4_dst     = n_l4_dst;
        o_raw.l2_ok      = n_l2_ok;
        o_raw.vlan_ok    = n_vlan_ok;
        o_raw.ip_ok      = n_ip_ok;
        o_raw.l4_pend    = n_l4_pend;
        o_raw.l4_ok      = n_l4_ok;
        o_raw.arp_done   = n_arp_done;
        o_raw.arp_addr   = n_arp_addr;
    end

    // Control registers; a frame end starts the next frame from scratch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_off <= '0; r_start <= '0; r_stage <= pfke_pkg::ST_ETH; r_need <= '0;
            r_hdr_ok <= 1'b0; r_snap_ok <= 1'b0; r_plen4 <= 1'b0;
            r_l2_ok <= 1'b0; r_vlan_ok <= 1'b0; r_ip_ok <= 1'b0;
            r_l4_pend <= 1'b0; r_l4_ok <= 1'b0; r_arp_done <= 1'b0; r_arp_addr <= 1'b0;
        end else begin
            r_off <= n_off; r_start <= n_start; r_stage <= n_stage; r_need <= n_need;
            r_hdr_ok <= n_hdr_ok; r_snap_ok <= n_snap_ok; r_plen4 <= n_plen4;
            r_l2_ok <= n_l2_ok; r_vlan_ok <= n_vlan_ok; r_ip_ok <= n_ip_ok;
            r_l4_pend <= n_l4_pend; r_l4_ok <= n_l4_ok;
            r_arp_done <= n_arp_done; r_arp_addr <= n_arp_addr;
        end
    end

    // Capture registers.
    always_ff @(posedge i_clk) begin
        r_port <= n_port; r_mac_dst <= n_mac_dst; r_mac_src <= n_mac_src;
        r_type <= n_type; r_tci <= n_tci; r_tmp <= n_tmp;
        r_ip_src <= n_ip_src; r_ip_dst <= n_ip_dst; r_proto <= n_proto; r_tos <= n_tos;
        r_l4_src <= n_l4_src; r_l4_dst <= n_l4_dst;
    end

endmodule
`default_nettype wire

[src/pfke_queue.sv]
// Short queue of parsed frames between the parser and the output stage.
`default_nettype none
module pfke_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pfke_pkg::t_raw i_raw,
    output logic                o_ready,
    output logic                o_valid,
    output pfke_pkg::t_raw      o_raw,
    input  wire logic           i_pop
);

    localparam int PW = (pfke_pkg::QUEUE_DEPTH > 1) ? $clog2(pfke_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(pfke_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(pfke_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(pfke_pkg::QUEUE_DEPTH - 1);

    pfke_pkg::t_raw r_mem [pfke_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_count;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_raw   = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_raw;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("pop from empty queue");
    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count != '0)) else $error("pushed item lost");
`endif

endmodule
`default_nettype wire

[src/pfke_resolve.sv]
// Output stage: turns captured fields and flags into the final key and holds it for the sink.
`default_nettype none
module pfke_resolve (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire pfke_pkg::t_raw i_raw,
    output logic                o_pop,
    pfke_key_if.source          o_key
);

    logic        r_valid;
    logic [15:0] r_port, r_vlan, r_ether_type, r_l4_src, r_l4_dst;
    logic [2:0]  r_pcp;
    logic [47:0] r_mac_src, r_mac_dst;
    logic [31:0] r_ip_src, r_ip_dst;
    logic [7:0]  r_proto, r_tos;
    logic        addr_ok;

    assign o_pop   = i_valid && (!r_valid || o_key.ready);
    assign addr_ok = i_raw.ip_ok || (i_raw.arp_done && i_raw.arp_addr);

    // Handshake state of the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_key.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Fields that a frame did not reach read as zero; the VLAN reads as VLAN_NONE.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_port       <= i_raw.port;
            r_mac_dst    <= i_raw.l2_ok ? i_raw.mac_dst : 48'h0;
            r_mac_src    <= i_raw.l2_ok ? i_raw.mac_src : 48'h0;
            r_ether_type <= i_raw.l2_ok ? i_raw.ether_type : 16'h0000;
            r_vlan       <= i_raw.vlan_ok ? {4'h0, i_raw.tci[11:0]} : pfke_pkg::VLAN_NONE;
            r_pcp        <= i_raw.vlan_ok ? i_raw.tci[15:13] : 3'd0;
            r_ip_src     <= addr_ok ? i_raw.ip_src : 32'h0;
            r_ip_dst     <= addr_ok ? i_raw.ip_dst : 32'h0;
            r_tos        <= i_raw.ip_ok ? i_raw.tos : 8'h00;
            if (i_raw.ip_ok) begin
                r_proto <= (i_raw.l4_pend && !i_raw.l4_ok) ? 8'h00 : i_raw.proto;
            end else begin
                r_proto <= i_raw.arp_done ? i_raw.proto : 8'h00;
            end
            r_l4_src     <= i_raw.l4_ok ? i_raw.l4_src : 16'h0000;
            r_l4_dst     <= i_raw.l4_ok ? i_raw.l4_dst : 16'h0000;
        end
    end

    assign o_key.valid          = r_valid;
    assign o_key.key_port       = r_port;
    assign o_key.key_vlan       = r_vlan;
    assign o_key.key_pcp        = r_pcp;
    assign o_key.key_mac_src    = r_mac_src;
    assign o_key.key_mac_dst    = r_mac_dst;
    assign o_key.key_ether_type = r_ether_type;
    assign o_key.key_ip_src     = r_ip_src;
    assign o_key.key_ip_dst     = r_ip_dst;
    assign o_key.key_ip_proto   = r_proto;
    assign o_key.key_tos        = r_tos;
    assign o_key.key_l4_src     = r_l4_src;
    assign o_key.key_l4_dst     = r_l4_dst;

endmodule
`default_nettype wire

[src/packet_flow_key_extractor.sv]
// Top level of the flow key extractor: parser, key queue and output stage.
// The block takes one frame byte per cycle and parses Ethernet II, LLC/SNAP, one VLAN tag,
// IPv4 with TCP, UDP or ICMP, and ARP as the bytes stream past; no frame is buffered.
// It accepts a byte in every cycle while the two-entry key queue has room, so sustained
// throughput is one item per cycle. The key of a frame enters the key queue when its last
// byte is accepted, then moves to the output register; the queue absorbs output stalls.
`default_nettype none
module packet_flow_key_extractor #(
    parameter int OFFSET_BITS = pfke_pkg::OFFSET_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfke_in_if.sink   i_in,
    pfke_key_if.source o_key
);

    pfke_pkg::t_raw push_raw, pop_raw;
    logic           push, q_ready, q_valid, pop;

    pfke_parse #(.OFFSET_BITS(OFFSET_BITS)) u_parse (
        .i_clk, .i_rst_n, .i_in, .i_q_ready(q_ready), .o_raw(push_raw), .o_push(push)
    );

    pfke_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_raw(push_raw), .o_ready(q_ready),
        .o_valid(q_valid), .o_raw(pop_raw), .i_pop(pop)
    );

    pfke_resolve u_resolve (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_raw(pop_raw), .o_pop(pop), .o_key
    );

endmodule
`default_nettype wire

[verif/tb_packet_flow_key_extractor.sv]
// Testbench of the flow key extractor: random and directed frames checked against a local parser.
`default_nettype none
module tb_packet_flow_key_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected flow key of one frame.
    typedef struct {
        logic [15:0] port;
        logic [15:0] vlan;
        logic [2:0]  pcp;
        logic [47:0] mac_src;
        logic [47:0] mac_dst;
        logic [15:0] ether_type;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [15:0] l4_src;
        logic [15:0] l4_dst;
    } t_flow_key;

    // Shadow parser and queue of pending flow keys.
    class flow_key_board;
        logic [7:0]  frame_buf[256];
        int unsigned frame_len;
        logic [15:0] frame_port;
        t_flow_key   pending[$];
        int          errors;

        function new();
            frame_len = 0;
            frame_port = 0;
            errors = 0;
            foreach (frame_buf[i]) frame_buf[i] = 0;
        endfunction

        function logic [7:0] b8(int unsigned i);
            return i < 256 ? frame_buf[i] : 8'h00;
        endfunction

        function logic [15:0] b16(int unsigned i);
            return {b8(i), b8(i + 1)};
        endfunction

        function logic [31:0] b32(int unsigned i);
            return {b16(i), b16(i + 2)};
        endfunction

        // Parse the captured frame into a flow key.
        function t_flow_key parse_frame(int unsigned len);
            t_flow_key k;
            int unsigned off, rest, ihl, l4len;
            logic [15:0] ety, tci;
            logic [7:0] pr;
            k = '{default: '0};
            k.port = frame_port;
            k.vlan = pfke_pkg::VLAN_NONE;
            if (len < 14) return k;
            off = 14;
            ety = b16(12);
            if (ety < pfke_pkg::ETH_LLC_LIMIT) begin
                if (len - off < 8) return k;
                if (b8(14) == 8'hAA && b8(15) == 8'hAA && b8(16) == 8'h03 &&
                    b8(17) == 0 && b8(18) == 0 && b8(19) == 0) begin
                    ety = b16(20);
                    off += 8;
                end else begin
                    ety = pfke_pkg::ETH_NON_SNAP;
                    off += 3;
                end
            end
            if (ety == pfke_pkg::ETH_VLAN && len - off >= 4) begin
                tci = b16(off);
                ety = b16(off + 2);
                k.vlan = {4'h0, tci[11:0]};
                k.pcp = tci[15:13];
                off += 4;
            end
            k.mac_src = {b16(6), b32(8)};
            k.mac_dst = {b16(0), b32(2)};
            k.ether_type = ety;
            rest = len - off;
            if (ety == pfke_pkg::ETH_IPV4) begin
                if (rest < 20) return k;
                ihl = b8(off) % 16 * 4;
                if (ihl < 20 || rest < ihl) return k;
                k.ip_src = b32(off + 12);
                k.ip_dst = b32(off + 16);
                pr = b8(off + 9);
                k.proto = pr;
                k.tos = b8(off + 1);
                if ((b16(off + 6) & pfke_pkg::FRAG_MASK) != 0) return k;
                off += ihl;
                rest = len - off;
                if (pr == pfke_pkg::PROTO_TCP) begin
                    l4len = rest >= 20 ? b8(off + 12) / 16 * 4 : 0;
                    if (l4len >= 20 && rest >= l4len) begin
                        k.l4_src = b16(off);
                        k.l4_dst = b16(off + 2);
                    end else k.proto = 0;
                end else if (pr == pfke_pkg::PROTO_UDP) begin
                    if (rest >= 8) begin
                        k.l4_src = b16(off);
                        k.l4_dst = b16(off + 2);
                    end else k.proto = 0;
                end else if (pr == pfke_pkg::PROTO_ICMP) begin
                    if (rest >= 4) begin
                        k.l4_src = {8'h00, b8(off)};
                        k.l4_dst = {8'h00, b8(off + 1)};
                    end else k.proto = 0;
                end
            end else if (ety == pfke_pkg::ETH_ARP) begin
                if (rest < 28) return k;
                if (b16(off + 2) == pfke_pkg::ETH_IPV4 && b8(off + 5) == 4) begin
                    k.ip_src = b32(off + 14);
                    k.ip_dst = b32(off + 24);
                end
                k.proto = b8(off + 7);
            end
            return k;
        endfunction

        // Note one accepted byte; the last byte of a frame yields a key.
        function void note_byte(logic [7:0] data, logic eop, logic [15:0] port);
            if (frame_len == 0) frame_port = port;
            if (frame_len < 256) frame_buf[frame_len] = data;
            if (frame_len < 255) frame_len++;
            if (eop) begin
                pending.push_back(parse_frame(frame_len));
                frame_len = 0;
            end
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Check one accepted key against the oldest expectation.
        function void check_key(t_flow_key a);
            t_flow_key e;
            if (pending.size() == 0) begin
                $error("flow key output with no frame pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("key_port", 64'(e.port), 64'(a.port));
            cmp("key_vlan", 64'(e.vlan), 64'(a.vlan));
            cmp("key_pcp", 64'(e.pcp), 64'(a.pcp));
            cmp("key_mac_src", 64'(e.mac_src), 64'(a.mac_src));
            cmp("key_mac_dst", 64'(e.mac_dst), 64'(a.mac_dst));
            cmp("key_ether_type", 64'(e.ether_type), 64'(a.ether_type));
            cmp("key_ip_src", 64'(e.ip_src), 64'(a.ip_src));
            cmp("key_ip_dst", 64'(e.ip_dst), 64'(a.ip_dst));
            cmp("key_ip_proto", 64'(e.proto), 64'(a.proto));
            cmp("key_tos", 64'(e.tos), 64'(a.tos));
            cmp("key_l4_src", 64'(e.l4_src), 64'(a.l4_src));
            cmp("key_l4_dst", 64'(e.l4_dst), 64'(a.l4_dst));
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    pfke_in_if  in_ch();
    pfke_key_if key_ch();

    packet_flow_key_extractor u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_key  (key_ch.source)
    );

    always #6 i_clk = ~i_clk;

    flow_key_board board = new();
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    bit in_done = 0;
    logic [7:0] frame_bytes[$];

    initial begin
        in_ch.valid = 0;
        in_ch.pkt_byte = 0;
        in_ch.end_of_packet = 0;
        in_ch.ingress_port = 0;
        key_ch.ready = 0;
    end

    function int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Watchdog and acceptance monitor.
    always @(posedge i_clk) begin
        t_flow_key a;
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_byte(in_ch.pkt_byte, in_ch.end_of_packet, in_ch.ingress_port);
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            a.port = key_ch.key_port;
            a.vlan = key_ch.key_vlan;
            a.pcp = key_ch.key_pcp;
            a.mac_src = key_ch.key_mac_src;
            a.mac_dst = key_ch.key_mac_dst;
            a.ether_type = key_ch.key_ether_type;
            a.ip_src = key_ch.key_ip_src;
            a.ip_dst = key_ch.key_ip_dst;
            a.proto = key_ch.key_ip_proto;
            a.tos = key_ch.key_tos;
            a.l4_src = key_ch.key_l4_src;
            a.l4_dst = key_ch.key_l4_dst;
            board.check_key(a);
        end
    end

    // Key output stalls, with quiet stretches of full readiness.
    initial begin
        int unsigned g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            g = ($urandom_range(0, 9) < 3) ? 0 : gap_len();
            if (g != 0) begin
                key_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            key_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Send one byte and wait for its acceptance.
    task automatic send_byte(logic [7:0] data, logic eop, logic [15:0] port, bit gaps);
        int unsigned g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pkt_byte <= data;
        in_ch.end_of_packet <= eop;
        in_ch.ingress_port <= port;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(logic [15:0] port, bit gaps);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, port, gaps);
        frame_bytes.delete();
    endtask

    task automatic put16(logic [15:0] v);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endtask

    task automatic put_rand(int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Build a mostly well-formed frame with random content and random cuts.
    task automatic build_frame(int unsigned kind);
        int unsigned l3, ihl, cut, pick;
        logic [7:0] pr;
        put_rand(12);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            put16(16'($urandom_range(0, 16'h05FF)));
            if ($urandom_range(0, 1)) begin
                frame_bytes.push_back(8'hAA);
                frame_bytes.push_back(8'hAA);
                frame_bytes.push_back(8'h03);
                put16(16'h0000);
                frame_bytes.push_back(8'h00);
            end else put_rand(3);
        end
        if (pick == 1) put16(pfke_pkg::ETH_VLAN);
        if (pick == 1 || pick == 2) begin
            put16(16'($urandom));
            if (pick == 2) begin
                put16(pfke_pkg::ETH_VLAN);
                put16(16'($urandom));
            end
        end
        l3 = $urandom_range(0, 9);
        if (kind == 0 || l3 < 6) begin
            put16(pfke_pkg::ETH_IPV4);
            ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
            frame_bytes.push_back({4'h4, 4'(ihl)});
            put_rand(5);
            case ($urandom_range(0, 3))
                0: put16(16'($urandom));
                1: put16(16'h4000);
                default: put16(16'h0000);
            endcase
            frame_bytes.push_back(8'($urandom));
            case ($urandom_range(0, 4))
                0: pr = pfke_pkg::PROTO_TCP;
                1: pr = pfke_pkg::PROTO_UDP;
                2: pr = pfke_pkg::PROTO_ICMP;
                3: pr = pfke_pkg::PROTO_TCP;
                default: pr = 8'($urandom);
            endcase
            frame_bytes.push_back(pr);
            put_rand(10);
            if (ihl > 5) put_rand((ihl - 5) * 4);
            put_rand(12);
            frame_bytes.push_back({4'($urandom_range(4, 8)), 4'($urandom)});
            put_rand($urandom_range(0, 20));
        end else if (l3 < 8) begin
            put16(pfke_pkg::ETH_ARP);
            put16(16'($urandom));
            put16($urandom_range(0, 1) ? pfke_pkg::ETH_IPV4 : 16'($urandom));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back($urandom_range(0, 1) ? 8'd4 : 8'($urandom));
            put_rand(22 + $urandom_range(0, 4));
        end else begin
            put_rand($urandom_range(2, 30));
        end
        // Occasionally truncate at any point, or pad into a long frame.
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end else if ($urandom_range(0, 30) == 0) begin
            put_rand($urandom_range(200, 300));
        end
    endtask

    // Directed frames, then random ones.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Single-byte frame and a 13-byte runt, extreme ports.
        frame_bytes.push_back(8'hFF);
        send_frame(16'hFFFF, 1'b0);
        put_rand(13);
        send_frame(16'h0000, 1'b0);
        // Short LLC header.
        put_rand(12); put16(16'h0000); put_rand(7);
        send_frame(16'h1234, 1'b0);
        // Non-SNAP LLC, then SNAP carrying IPv4/UDP.
        put_rand(12); put16(16'h05FF); put_rand(8);
        send_frame(16'h8000, 1'b0);
        put_rand(12); put16(16'h0010);
        frame_bytes.push_back(8'hAA); frame_bytes.push_back(8'hAA);
        frame_bytes.push_back(8'h03); put16(16'h0000); frame_bytes.push_back(8'h00);
        put16(pfke_pkg::ETH_IPV4); frame_bytes.push_back(8'h45); put_rand(5);
        put16(16'h0000);
        frame_bytes.push_back(8'd64); frame_bytes.push_back(pfke_pkg::PROTO_UDP);
        put_rand(10); put_rand(8);
        send_frame(16'h0001, 1'b0);
        // Truncated VLAN tag, and all-ones bytes.
        put_rand(12); put16(pfke_pkg::ETH_VLAN); put_rand(3);
        send_frame(16'h00FF, 1'b0);
        repeat (60) frame_bytes.push_back(8'hFF);
        send_frame(16'hFFFF, 1'b0);
        // Mostly well-formed IPv4 frames.
        repeat (20) begin
            build_frame(0);
            send_frame(16'($urandom), 1'b0);
        end
        while (bytes_sent < 1950) begin
            build_frame($urandom_range(0, 3));
            send_frame(16'($urandom), $urandom_range(0, 3) != 0);
        end
        in_ch.valid <= 1'b0;
        in_done = 1;
    end

    // End of run.
    initial begin
        wait (in_done);
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
